@@ rtl/threshold_pixel_page_packer_macros.svh @@
`ifndef THRESHOLD_PIXEL_PAGE_PACKER_MACROS_SVH
`define THRESHOLD_PIXEL_PAGE_PACKER_MACROS_SVH

// same-cycle implication, off during reset
`define TPPP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TPPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked at every edge, reset included
`define TPPP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/tppp_pkg.sv @@
`timescale 1ns / 1ps
package tppp_pkg;

    localparam int MAX_WIDTH_DEF  = 84;
    localparam int MAX_HEIGHT_DEF = 48;

    localparam logic [7:0] PAGE_CMD   = 8'h40;
    localparam logic [7:0] COLUMN_CMD = 8'h80;
    localparam int         BAND_ROWS  = 8;
    localparam int         ENTRY_W    = BAND_ROWS - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] THRESHOLD_RST    = 8'd128;
    localparam logic [6:0] IMAGE_WIDTH_RST  = 7'd84;
    localparam logic [5:0] IMAGE_HEIGHT_RST = 6'd48;
    localparam logic [6:0] START_COLUMN_RST = 7'd0;
    localparam logic [2:0] START_PAGE_RST   = 3'd0;

    typedef enum logic [2:0] {
        REG_THRESHOLD    = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_START_COLUMN = 3'd3,
        REG_START_PAGE   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [7:0] threshold;
        logic [6:0] image_width;
        logic [5:0] image_height;
        logic [6:0] start_column;
        logic [2:0] start_page;
    } cfg_t;

    // one band byte waiting for the output side
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] page_byte;
        logic       with_cmd;
        logic       end_img;
    } job_t;

endpackage

@@ rtl/pixel_if.sv @@
`timescale 1ns / 1ps
interface pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

@@ rtl/lcd_if.sv @@
`timescale 1ns / 1ps
interface lcd_if;
    logic       valid;
    logic       ready;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last_of_run;
    logic       end_of_image;

    modport source (output valid, output lcd_byte, output is_data, output last_of_run,
                    output end_of_image, input ready);
    modport sink (input valid, input lcd_byte, input is_data, input last_of_run,
                  input end_of_image, output ready);
endinterface

@@ rtl/tppp_ram.sv @@
`timescale 1ns / 1ps
module tppp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tppp_front.sv @@
`timescale 1ns / 1ps
module tppp_front
    import tppp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    pixel_if.sink             pix,
    input  cfg_t              cfg,
    input  logic              restart,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push_valid,
    output job_t              push_job
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [8:0]       w_raw, h_raw, w_eff, h_eff;
    logic             col_last, row_last, band_last, accept;
    logic [QCNT_W:0]  in_flight;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [2:0]       s1_r_reg;
    logic             s1_dark_reg;
    logic             s1_last_reg;
    logic             s1_cmd_reg;
    logic             s1_end_reg;
    logic [7:0]       s1_page_reg;

    logic               fwd_valid_reg;
    logic [COL_W-1:0]   fwd_addr_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic [ENTRY_W-1:0] rd_data, entry;
    logic [7:0]         mask, new_byte;
    logic               wr_en;

    always_comb
    begin
        w_raw = 9'(cfg.image_width);
        h_raw = 9'(cfg.image_height);
        if (w_raw == 9'd0)
            w_eff = 9'd1;
        else if (w_raw > 9'(MAX_WIDTH))
            w_eff = 9'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw == 9'd0)
            h_eff = 9'd1;
        else if (h_raw > 9'(MAX_HEIGHT))
            h_eff = 9'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    assign col_last  = (9'(col_reg) == (w_eff - 9'd1));
    assign row_last  = (9'(row_reg) == (h_eff - 9'd1));
    assign band_last = (row_reg[2:0] == 3'(BAND_ROWS - 1)) || row_last;

    // room for everything already in flight plus one more word
    assign in_flight = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_reg);
    assign pix.ready = (in_flight < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_reg;
            s1_r_reg    <= row_reg[2:0];
            s1_dark_reg <= (pix.pixel <= cfg.threshold);
            s1_last_reg <= band_last;
            s1_cmd_reg  <= (col_reg == '0);
            s1_end_reg  <= row_last && col_last;
            s1_page_reg <= PAGE_CMD + 8'(cfg.start_page) + 8'(row_reg >> 3);
        end
        fwd_addr_reg <= s1_col_reg;
        fwd_data_reg <= new_byte[ENTRY_W-1:0];
    end

    tppp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_band_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_col_reg),
        .wdata (new_byte[ENTRY_W-1:0]),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    // previous cycle's write to the same column is not yet visible in the read
    assign entry    = (fwd_valid_reg && (fwd_addr_reg == s1_col_reg)) ? fwd_data_reg : rd_data;
    assign mask     = (8'd1 << s1_r_reg) - 8'd1;
    assign new_byte = ({1'b0, entry} & mask) | (8'(s1_dark_reg) << s1_r_reg);
    assign wr_en    = s1_valid_reg && !s1_last_reg;

    assign push_valid         = s1_valid_reg && s1_last_reg;
    assign push_job.data_byte = new_byte;
    assign push_job.page_byte = s1_page_reg;
    assign push_job.with_cmd  = s1_cmd_reg;
    assign push_job.end_img   = s1_end_reg;

endmodule

@@ rtl/tppp_queue.sv @@
`timescale 1ns / 1ps
module tppp_queue
    import tppp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  job_t              push_job,
    input  logic              pop,
    output logic              head_valid,
    output job_t              head_job,
    output logic [QCNT_W-1:0] count
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_valid)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (do_pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(push_valid) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            slot_reg[wptr_reg] <= push_job;
    end

endmodule

@@ rtl/tppp_back.sv @@
`timescale 1ns / 1ps
module tppp_back
    import tppp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    input  logic [6:0] start_column,
    output logic       pop,
    lcd_if.source      lcd
);

    typedef enum logic [2:0] {
        ST_PAGE   = 3'b001,
        ST_COLUMN = 3'b010,
        ST_DATA   = 3'b100
    } phase_t;

    phase_t     state_reg, state_next;
    logic       o_valid_reg, o_valid_next;
    logic [7:0] o_byte_reg, o_byte_next;
    logic       o_data_reg, o_data_next;
    logic       o_last_reg, o_last_next;
    logic       o_end_reg, o_end_next;
    logic       load;

    assign load = !o_valid_reg || lcd.ready;

    always_comb
    begin
        state_next   = state_reg;
        o_valid_next = o_valid_reg && !lcd.ready;
        o_byte_next  = o_byte_reg;
        o_data_next  = o_data_reg;
        o_last_next  = o_last_reg;
        o_end_next   = o_end_reg;
        pop          = 1'b0;
        if (load && head_valid)
        begin
            o_valid_next = 1'b1;
            o_byte_next  = head_job.data_byte;
            o_data_next  = 1'b1;
            o_last_next  = 1'b1;
            o_end_next   = head_job.end_img;
            unique case (state_reg)
                ST_PAGE:
                begin
                    if (head_job.with_cmd)
                    begin
                        o_byte_next = head_job.page_byte;
                        o_data_next = 1'b0;
                        o_last_next = 1'b0;
                        o_end_next  = 1'b0;
                        state_next  = ST_COLUMN;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                ST_COLUMN:
                begin
                    o_byte_next = COLUMN_CMD + 8'(start_column);
                    o_data_next = 1'b0;
                    o_last_next = 1'b0;
                    o_end_next  = 1'b0;
                    state_next  = ST_DATA;
                end
                ST_DATA:
                begin
                    pop        = 1'b1;
                    state_next = ST_PAGE;
                end
                default:
                begin
                    state_next = ST_PAGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_PAGE;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_byte_reg <= o_byte_next;
        o_data_reg <= o_data_next;
        o_last_reg <= o_last_next;
        o_end_reg  <= o_end_next;
    end

    assign lcd.valid        = o_valid_reg;
    assign lcd.lcd_byte     = o_byte_reg;
    assign lcd.is_data      = o_data_reg;
    assign lcd.last_of_run  = o_last_reg;
    assign lcd.end_of_image = o_end_reg;

endmodule

@@ rtl/threshold_pixel_page_packer.sv @@
// Binarizes grey pixels (raster order, at or below threshold = dark bit 1) and packs each
// band of eight rows into display bytes, bit k = band row k, one byte per column when the
// band's last row arrives; the first column of a band is preceded by a set-page and a
// set-column command word. Takes one pixel per cycle while the queue has room, with a
// band-store read per pixel and a write outside the band's last row; a four-entry queue
// separates the front end from the output sequencer, which sends one word per cycle while
// the display is ready. The two band-start command words cost the input a stall even when
// the output never stalls; images so narrow that band rows yield more words than pixels
// run at the output's pace. Any configuration write restarts the frame at row 0, column 0.
`timescale 1ns / 1ps
module threshold_pixel_page_packer
    import tppp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    pixel_if.sink      pix,
    lcd_if.source      lcd
);

    cfg_t              cfg_reg;
    logic              restart;
    logic              push_valid;
    job_t              push_job;
    logic              pop;
    logic              head_valid;
    job_t              head_job;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= THRESHOLD_RST;
            cfg_reg.image_width  <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.start_column <= START_COLUMN_RST;
            cfg_reg.start_page   <= START_PAGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    cfg_reg.threshold    <= cfg_data;
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[6:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[5:0];
                REG_START_COLUMN: cfg_reg.start_column <= cfg_data[6:0];
                REG_START_PAGE:   cfg_reg.start_page   <= cfg_data[2:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index <= REG_START_PAGE);

    tppp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg_reg),
        .restart    (restart),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    tppp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    tppp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .start_column (cfg_reg.start_column),
        .pop          (pop),
        .lcd          (lcd)
    );

endmodule

@@ rtl/tppp_checker.sv @@
`timescale 1ns / 1ps
`include "threshold_pixel_page_packer_macros.svh"
module tppp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] lcd_byte,
    input logic       is_data,
    input logic       last_of_run,
    input logic       end_of_image
);

    `TPPP_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n, !out_valid, "word valid during reset")

    `TPPP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(lcd_byte), "stalled word changed")

    `TPPP_ASSERT_IMPLY(a_cmd_flags, clk, rst_n, out_valid && !is_data, !last_of_run && !end_of_image, "command word carries data flags")

    `TPPP_ASSERT_NEXT(a_page_then_col, clk, rst_n, out_valid && out_ready && !is_data && !lcd_byte[7], out_valid && !is_data && lcd_byte[7], "set page not followed by set column")

endmodule

bind threshold_pixel_page_packer tppp_checker u_tppp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (lcd.valid),
    .out_ready    (lcd.ready),
    .lcd_byte     (lcd.lcd_byte),
    .is_data      (lcd.is_data),
    .last_of_run  (lcd.last_of_run),
    .end_of_image (lcd.end_of_image)
);
